### hw/rtl/pica_pkg.sv
// ----------------------------------------------------------------------------
// PI controller package
// Shared types, constants, arithmetic helpers and the microcode program of the
// PI controller with clamping anti-windup.
// ----------------------------------------------------------------------------
package pica_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int DT_FRAC_BITS = 16;
    localparam int Q_W          = 32;
    localparam int DT_W         = 16;
    localparam int STEP_W       = 4;
    localparam int CFG_IDX_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_KP      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KI      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = CFG_IDX_W'(3);

    localparam logic signed [Q_W-1:0] KP_RESET = 32'sd65536;
    localparam logic signed [Q_W-1:0] Q_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN    = 32'sh8000_0000;

    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_DONE  = STEP_W'(10);

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_ERR   = 4'd1,
        OP_MUL   = 4'd2,
        OP_PROP  = 4'd3,
        OP_GAIN  = 4'd4,
        OP_INTEG = 4'd5,
        OP_SUM   = 4'd6,
        OP_LIMIT = 4'd7,
        OP_BACK  = 4'd8
    } t_op;

    typedef enum logic {
        A_ERR  = 1'b0,
        A_GAIN = 1'b1
    } t_asel;

    typedef enum logic [1:0] {
        B_KP = 2'd0,
        B_KI = 2'd1,
        B_DT = 2'd2
    } t_bsel;

    typedef struct packed {
        t_op               op;
        t_asel             a_sel;
        t_bsel             b_sel;
        logic              jmp_nlim;
        logic [STEP_W-1:0] target;
        logic              last;
    } t_cword;

    // Datapath controls for the current step.
    typedef struct packed {
        logic  en;
        logic  load;
        t_op   op;
        t_asel a_sel;
        t_bsel b_sel;
    } t_ctrl;

    // Datapath flags that steer the program.
    typedef struct packed {
        logic lim;
    } t_status;

    // The control program: one word per step.
    function automatic t_cword ucode(input logic [STEP_W-1:0] step);
        t_cword cw;
        cw = '{op: OP_NONE, a_sel: A_ERR, b_sel: B_KP, jmp_nlim: 1'b0,
               target: STEP_FIRST, last: 1'b0};
        case (step)
            STEP_W'(0): cw.op = OP_ERR;
            STEP_W'(1): begin
                cw.op = OP_MUL; cw.a_sel = A_ERR; cw.b_sel = B_KP;
            end
            STEP_W'(2): cw.op = OP_PROP;
            STEP_W'(3): begin
                cw.op = OP_MUL; cw.a_sel = A_ERR; cw.b_sel = B_KI;
            end
            STEP_W'(4): cw.op = OP_GAIN;
            STEP_W'(5): begin
                cw.op = OP_MUL; cw.a_sel = A_GAIN; cw.b_sel = B_DT;
            end
            STEP_W'(6): cw.op = OP_INTEG;
            STEP_W'(7): cw.op = OP_SUM;
            STEP_W'(8): begin
                // Skip the back-calculation when the clamp left the sum alone.
                cw.op = OP_LIMIT; cw.jmp_nlim = 1'b1; cw.target = STEP_DONE;
            end
            STEP_W'(9): cw.op = OP_BACK;
            default:    cw.last = 1'b1;
        endcase
        return cw;
    endfunction

    function automatic logic signed [Q_W-1:0] sat64(input logic signed [63:0] x);
        logic signed [Q_W-1:0] r;
        if (x > 64'(Q_MAX)) begin
            r = Q_MAX;
        end else if (x < 64'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = x[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b,
                                                      input logic sub);
        logic signed [Q_W:0] s;
        logic signed [Q_W-1:0] r;
        if (sub) begin
            s = {a[Q_W-1], a} - {b[Q_W-1], b};
        end else begin
            s = {a[Q_W-1], a} + {b[Q_W-1], b};
        end
        if (s[Q_W] != s[Q_W-1]) begin
            r = s[Q_W] ? Q_MIN : Q_MAX;
        end else begin
            r = s[Q_W-1:0];
        end
        return r;
    endfunction

    // Raise to the lower limit first, then lower to the upper one.
    function automatic logic signed [Q_W-1:0] clamp(input logic signed [Q_W-1:0] v,
                                                    input logic signed [Q_W-1:0] lo,
                                                    input logic signed [Q_W-1:0] hi);
        logic signed [Q_W-1:0] r;
        r = (v < lo) ? lo : v;
        if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

### hw/rtl/pi_controller_anti_windup.sv
// ----------------------------------------------------------------------------
// PI controller with clamping anti-windup
// Top level: stream ports, configuration port and the output register.
// ----------------------------------------------------------------------------
// Usage
//   Each transfer on the slave stream is one control tick: measured value,
//   reference and time step in s_axis_tdata, the restart flag in s_axis_tuser.
//   Each tick gives exactly one transfer on the master stream: the clamped
//   drive in m_axis_tdata and the limited flag in m_axis_tuser.
//   The gains and output limits are written through the i_cfg_* port while no
//   tick is in progress; writes to indexes above 3 are ignored.
//   A tick runs through a ten-step microcode program on one shared 33 x 33
//   multiplier, one step per cycle, except that the last step waits for a
//   free output register; the integral is recalculated only when the clamp
//   acts. A new tick is taken only once the previous one has finished.
//   The result sits in an output register, so the next tick is accepted while
//   it waits; if the receiver stalls, the following tick halts at its last step
//   until the register is free.
//   Synchronous reset restores the register defaults (kp 1.0, ki 0, full-range
//   limits), clears the integral and empties the output register.
// ----------------------------------------------------------------------------
module pi_controller_anti_windup (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pica_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pica_pkg::Q_W-1:0]       i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // measured [31:0], reference [63:32], time_step [79:64]
    input  logic [79:0]                    s_axis_tdata,
    // restart [0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // drive [31:0]
    output logic [31:0]                    m_axis_tdata,
    // limited [0]
    output logic                           m_axis_tuser
);
    import pica_pkg::*;

    t_ctrl                 ctrl;
    t_status               status;
    logic                  out_load;
    logic signed [Q_W-1:0] drive;
    logic                  limited;

    logic                  r_out_valid;
    logic [Q_W-1:0]        r_out_drive;
    logic                  r_out_lim;

    pica_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_full  (r_out_valid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_ctrl      (ctrl),
        .o_out_load  (out_load)
    );

    pica_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_measured  (s_axis_tdata[31:0]),
        .i_reference (s_axis_tdata[63:32]),
        .i_time_step (s_axis_tdata[79:64]),
        .i_restart   (s_axis_tuser),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .o_drive     (drive),
        .o_limited   (limited)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_drive <= drive;
            r_out_lim   <= limited;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_drive;
    assign m_axis_tuser  = r_out_lim;

endmodule

### hw/rtl/pica_sequencer.sv
// ----------------------------------------------------------------------------
// PI controller sequencer
// Step counter over the microcode program, with the conditional jump and the
// input and output handshakes.
// ----------------------------------------------------------------------------
module pica_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_full,
    input  logic              i_out_ready,
    input  pica_pkg::t_status i_status,
    output pica_pkg::t_ctrl   o_ctrl,
    output logic              o_out_load
);
    import pica_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_cword            cw;
    logic              accept;
    logic              out_free;

    assign cw       = ucode(r_step);
    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign out_free = !i_out_full || i_out_ready;

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_load = (r_state == ST_RUN) && cw.last && out_free;

    always_comb begin
        o_ctrl.en    = (r_state == ST_RUN) && !cw.last;
        o_ctrl.load  = accept;
        o_ctrl.op    = cw.op;
        o_ctrl.a_sel = cw.a_sel;
        o_ctrl.b_sel = cw.b_sel;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RUN;
                    n_step  = STEP_FIRST;
                end
            end
            ST_RUN: begin
                if (cw.last) begin
                    // The last step waits until the output register can take the result.
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (cw.jmp_nlim && !i_status.lim) begin
                    n_step = cw.target;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_FIRST;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

### hw/rtl/pica_datapath.sv
// ----------------------------------------------------------------------------
// PI controller datapath
// Configuration registers, operand latches, one shared multiplier and the
// saturating adder and clamp, each driven by the current control word.
// ----------------------------------------------------------------------------
module pica_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pica_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pica_pkg::Q_W-1:0]            i_cfg_data,
    input  logic signed [pica_pkg::Q_W-1:0]     i_measured,
    input  logic signed [pica_pkg::Q_W-1:0]     i_reference,
    input  logic [pica_pkg::DT_W-1:0]           i_time_step,
    input  logic                                i_restart,
    input  pica_pkg::t_ctrl                     i_ctrl,
    output pica_pkg::t_status                   o_status,
    output logic signed [pica_pkg::Q_W-1:0]     o_drive,
    output logic                                o_limited
);
    import pica_pkg::*;

    logic signed [Q_W-1:0]  r_kp, r_ki, r_out_min, r_out_max;
    logic signed [Q_W-1:0]  r_meas, r_ref;
    logic [DT_W-1:0]        r_dt;
    logic                   r_restart;
    logic signed [Q_W-1:0]  r_err, r_prop, r_gain, r_integ, r_sum, r_drive;
    logic                   r_lim;
    logic signed [63:0]     r_prod;

    logic signed [Q_W:0]    mul_a, mul_b;
    logic signed [2*Q_W+1:0] mul_p;
    logic signed [63:0]     sh_frac, sh_dt;
    logic signed [Q_W-1:0]  lim_v;

    always_comb begin
        mul_a = (i_ctrl.a_sel == A_GAIN) ? {r_gain[Q_W-1], r_gain} : {r_err[Q_W-1], r_err};
        case (i_ctrl.b_sel)
            B_KP:    mul_b = {r_kp[Q_W-1], r_kp};
            B_KI:    mul_b = {r_ki[Q_W-1], r_ki};
            B_DT:    mul_b = {(Q_W+1-DT_W)'(0), r_dt};
            default: mul_b = '0;
        endcase
    end

    // The true product always fits in 64 bits.
    assign mul_p   = mul_a * mul_b;
    assign sh_frac = r_prod >>> FRAC_BITS;
    assign sh_dt   = r_prod >>> DT_FRAC_BITS;
    assign lim_v   = clamp(r_sum, r_out_min, r_out_max);

    assign o_status.lim = (lim_v != r_sum);
    assign o_drive      = r_drive;
    assign o_limited    = r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= KP_RESET;
            r_ki      <= '0;
            r_out_min <= Q_MIN;
            r_out_max <= Q_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KP:      r_kp      <= i_cfg_data;
                REG_KI:      r_ki      <= i_cfg_data;
                REG_OUT_MIN: r_out_min <= i_cfg_data;
                REG_OUT_MAX: r_out_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_meas    <= i_measured;
            r_ref     <= i_reference;
            r_dt      <= i_time_step;
            r_restart <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_ctrl.en) begin
            case (i_ctrl.op)
                OP_ERR:   if (r_restart) r_integ <= '0;
                OP_INTEG: r_integ <= sat_add(r_integ, sh_dt[Q_W-1:0], 1'b0);
                OP_BACK:  r_integ <= sat_add(r_drive, r_prop, 1'b1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            unique case (i_ctrl.op)
                OP_NONE:  ;
                OP_ERR:   r_err  <= sat_add(r_ref, r_meas, 1'b1);
                OP_MUL:   r_prod <= mul_p[63:0];
                OP_PROP:  r_prop <= clamp(sat64(sh_frac), r_out_min, r_out_max);
                OP_GAIN:  r_gain <= sat64(sh_frac);
                OP_INTEG: ;
                OP_SUM:   r_sum  <= sat_add(r_prop, r_integ, 1'b0);
                OP_LIMIT: begin
                    r_drive <= lim_v;
                    r_lim   <= o_status.lim;
                end
                OP_BACK:  ;
                default: ;
            endcase
        end
    end

endmodule
